### sv/i2afmt_pkg.sv
`default_nettype none

package i2afmt_pkg;

    // format selector codes
    localparam logic [2:0] ACT_CHAR  = 3'd0;
    localparam logic [2:0] ACT_SDEC  = 3'd1;
    localparam logic [2:0] ACT_UDEC  = 3'd2;
    localparam logic [2:0] ACT_HEXLO = 3'd3;
    localparam logic [2:0] ACT_HEXUP = 3'd4;

    // ASCII
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_NINE  = 8'h39;
    localparam logic [7:0] CHR_LOWA  = 8'h61;
    localparam logic [7:0] CHR_UPA   = 8'h41;
    localparam logic [7:0] CHR_MINUS = 8'h2D;

    localparam int TEXT_MAX = 16;

    // ceil(2^35 / 10): q = (x * RECIP10) >> 35 is exact for any 32-bit x
    localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

    typedef struct packed {
        logic hex;
        logic upper;
    } digit_ctl_t;

endpackage

`default_nettype wire

### sv/i2afmt_digit_unit.sv
`default_nettype none

// Shared digit unit: peels off the lowest digit of the operand and
// returns its ASCII code together with the remaining operand.
module i2afmt_digit_unit (
    input  wire i2afmt_pkg::digit_ctl_t ctl,
    input  wire logic [63:0]            operand,
    output logic [7:0]                  digit_char,
    output logic [63:0]                 next_operand
);
    import i2afmt_pkg::*;

    logic [63:0] prod;
    logic [31:0] quot;
    logic [31:0] rem32;
    logic [3:0]  nib;
    logic [3:0]  digit;

    // divide by ten through the reciprocal, remainder by shift-add back
    assign prod  = {32'd0, operand[31:0]} * {32'd0, RECIP10};
    assign quot  = {3'd0, prod[63:35]};
    assign rem32 = operand[31:0] - ((quot << 3) + (quot << 1));

    assign nib   = operand[3:0];
    assign digit = ctl.hex ? nib : rem32[3:0];

    always_comb
    begin
        if (digit <= 4'd9)
        begin
            digit_char = CHR_ZERO + {4'd0, digit};
        end
        else
        begin
            digit_char = (ctl.upper ? CHR_UPA : CHR_LOWA) + {4'd0, digit} - 8'd10;
        end
    end

    assign next_operand = ctl.hex ? {4'd0, operand[63:4]} : {32'd0, quot};

endmodule

`default_nettype wire

### sv/integer_to_ascii_formatter_top.sv
`default_nettype none

// Channel  | handshake           | payload
// ---------+---------------------+-------------------------------
// in       | in_valid / in_stall | action[2:0], value[63:0]
// out      | out_valid/out_stall | out_char[7:0], last, length[4:0]
//
// Accepts an item only when idle; then, but for a raw byte, one digit per
// cycle comes out of the shared divide-by-ten / shift-by-four unit (up to 10
// decimal, 16 hex digits), then the text leaves one beat per cycle from a
// 16-entry buffer, sign first.
// rst_n clears the sequencer and the output valid; the buffer is not reset.
// out_stall only holds the output register and lengthens the emit phase.
module integer_to_ascii_formatter_top (
    input  wire  logic        clk,
    input  wire  logic        rst_n,
    input  wire  logic        in_valid,
    output logic              in_stall,
    input  wire  logic [2:0]  action,
    input  wire  logic [63:0] value,
    output logic              out_valid,
    input  wire  logic        out_stall,
    output logic [7:0]        out_char,
    output logic              last,
    output logic [4:0]        length
);
    import i2afmt_pkg::*;

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [63:0] mag_reg, mag_next;        // operand still to convert
    digit_ctl_t  ctl_reg, ctl_next;
    logic        neg_reg, neg_next;        // minus sign still to send
    logic [4:0]  n_reg, n_next;            // digits stored so far
    logic [4:0]  rem_reg, rem_next;        // digits left to send
    logic [4:0]  len_reg, len_next;        // total text length

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_char_reg, out_char_next;
    logic        out_last_reg, out_last_next;
    logic [4:0]  out_len_reg, out_len_next;

    // digit buffer, least significant digit at entry 0
    logic [7:0]  buf_mem [TEXT_MAX];
    logic        wr_en;
    logic [3:0]  wr_addr;
    logic [7:0]  wr_data;
    logic [3:0]  rd_idx;
    logic        char_from_buf;            // next out_char comes from the buffer

    logic        in_fire;
    logic        out_free;
    logic [7:0]  digit_char;
    logic [63:0] next_operand;
    logic [31:0] abs_w;

    i2afmt_digit_unit u_digit (
        .ctl          (ctl_reg),
        .operand      (mag_reg),
        .digit_char   (digit_char),
        .next_operand (next_operand)
    );

    assign in_stall = (state_reg != ST_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign abs_w   = value[31] ? (~value[31:0] + 32'd1) : value[31:0];
    assign rd_idx  = 4'(rem_reg - 5'd1);

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        ctl_next       = ctl_reg;
        neg_next       = neg_reg;
        n_next         = n_reg;
        rem_next       = rem_reg;
        len_next       = len_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_len_next   = out_len_reg;
        char_from_buf  = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = n_reg[3:0];
        wr_data        = digit_char;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    n_next        = 5'd0;
                    neg_next      = 1'b0;
                    ctl_next.hex  = 1'b0;
                    ctl_next.upper = 1'b0;
                    case (action)
                        ACT_CHAR:
                        begin
                            // raw byte, a zero byte goes out as is
                            wr_en      = 1'b1;
                            wr_addr    = 4'd0;
                            wr_data    = value[7:0];
                            rem_next   = 5'd1;
                            len_next   = 5'd1;
                            state_next = ST_EMIT;
                        end
                        ACT_SDEC:
                        begin
                            neg_next   = value[31];
                            mag_next   = {32'd0, abs_w};
                            state_next = ST_CONV;
                        end
                        ACT_UDEC:
                        begin
                            mag_next   = {32'd0, value[31:0]};
                            state_next = ST_CONV;
                        end
                        ACT_HEXLO, ACT_HEXUP:
                        begin
                            mag_next       = value;
                            ctl_next.hex   = 1'b1;
                            ctl_next.upper = (action == ACT_HEXUP);
                            state_next     = ST_CONV;
                        end
                        default:
                        begin
                            // unused selector: no text
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CONV:
            begin
                wr_en    = 1'b1;
                n_next   = n_reg + 5'd1;
                mag_next = next_operand;
                if (next_operand == 64'd0)
                begin
                    rem_next   = n_reg + 5'd1;
                    len_next   = n_reg + 5'd1 + {4'd0, neg_reg};
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (neg_reg)
                    begin
                        out_char_next = CHR_MINUS;
                        out_last_next = 1'b0;
                        out_len_next  = 5'd0;
                        neg_next      = 1'b0;
                    end
                    else
                    begin
                        char_from_buf = 1'b1;
                        rem_next      = rem_reg - 5'd1;
                        if (rem_reg == 5'd1)
                        begin
                            out_last_next = 1'b1;
                            out_len_next  = len_reg;
                            state_next    = ST_IDLE;
                        end
                        else
                        begin
                            out_last_next = 1'b0;
                            out_len_next  = 5'd0;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            neg_reg       <= 1'b0;
            n_reg         <= 5'd0;
            rem_reg       <= 5'd0;
            len_reg       <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            neg_reg       <= neg_next;
            n_reg         <= n_next;
            rem_reg       <= rem_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        ctl_reg      <= ctl_next;
        out_last_reg <= out_last_next;
        out_len_reg  <= out_len_next;
        if (char_from_buf)
        begin
            out_char_reg <= buf_mem[rd_idx];
        end
        else
        begin
            out_char_reg <= out_char_next;
        end
        if (wr_en)
        begin
            buf_mem[wr_addr] <= wr_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last      = out_last_reg;
    assign length    = out_len_reg;

`ifndef NO_ASSERTIONS
    // digit count never runs past the buffer
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= 5'd16)
        else $error("digit count overflow");

    // reciprocal divide must yield a decimal digit
    a_dec_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONV && !ctl_reg.hex) |->
            (digit_char >= CHR_ZERO && digit_char <= CHR_NINE))
        else $error("decimal digit out of range");

    // final beat carries a length in 1..16
    a_last_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |-> (length != 5'd0 && length <= 5'd16))
        else $error("bad length on last beat");

    // non-final beats carry zero length
    a_mid_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |-> (length == 5'd0))
        else $error("length on non-final beat");
`endif

endmodule

`default_nettype wire
